// ===== src/cprs_pkg.sv =====
// Package with shared types, constants and helpers of the contiguous page run splitter.
package cprs_pkg;

  // Default sizing of the buffer and of the frame number space.
  localparam int unsigned MAX_PAGES_DEF  = 2048;
  localparam int unsigned FRAME_BITS_DEF = 40;

  // Fixed field widths of the items.
  localparam int unsigned FRAME_W = 40;
  localparam int unsigned START_W = 11;
  localparam int unsigned RUN_W   = 12;
  localparam int unsigned LOG2_W  = 4;

  // Largest set size exponent and the reset value of the register.
  localparam logic [LOG2_W-1:0] LOG2_LIMIT       = 4'd11;
  localparam logic [LOG2_W-1:0] MAX_SET_LOG2_RST = 4'd9;

  // Register indexes on the configuration port.
  localparam logic REG_MAX_SET_LOG2 = 1'b0;

  // One input item: a page of the buffer.
  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic               last_page;
  } in_item_t;

  // One result item: a page set.
  typedef struct packed {
    logic [START_W-1:0] set_start;
    logic [RUN_W-1:0]   set_pages;
    logic               last_set;
    logic               overflow;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEG_A,
    ST_SEG_B
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit_a;
    logic emit_b;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic a_go;
    logic b_go;
    logic a_done;
    logic b_done;
    logic b_left;
    logic out_free;
  } dp_status_t;

  // Largest power of two not above a length (zero for zero).
  function automatic logic [RUN_W-1:0] top_pow2(input logic [RUN_W-1:0] len);
    logic [RUN_W-1:0] res;
    res = '0;
    for (int i = 0; i < RUN_W; i++) begin
      if (len[i]) begin
        res = RUN_W'(1) << i;
      end
    end
    return res;
  endfunction

  // Limit the configured set size exponent.
  function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] v);
    return (v > LOG2_LIMIT) ? LOG2_LIMIT : v;
  endfunction

endpackage

// ===== src/cprs_ctrl.sv =====
// Controller state machine that sequences item loads and set emission.
module cprs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cprs_pkg::dp_status_t status_i,
  output cprs_pkg::dp_cmd_t    cmd_o
);
  import cprs_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.a_go) begin
            state_d = ST_SEG_A;
          end else if (status_i.b_go) begin
            state_d = ST_SEG_B;
          end
        end
      end
      ST_SEG_A: begin
        if (status_i.out_free && status_i.a_done) begin
          state_d = status_i.b_left ? ST_SEG_B : ST_IDLE;
        end
      end
      ST_SEG_B: begin
        if (status_i.out_free && status_i.b_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SEG_A: cmd_o.emit_a = status_i.out_free;
      ST_SEG_B: cmd_o.emit_b = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== src/cprs_datapath.sv =====
// Datapath with the run tracking state, the two pending segments and the output register.
module cprs_datapath #(
  parameter int unsigned MAX_PAGES  = cprs_pkg::MAX_PAGES_DEF,
  parameter int unsigned FRAME_BITS = cprs_pkg::FRAME_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cprs_pkg::in_item_t                  in_item_i,
  input  logic [cprs_pkg::LOG2_W-1:0]         max_set_log2_i,
  input  cprs_pkg::dp_cmd_t                   cmd_i,
  output cprs_pkg::dp_status_t                status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output cprs_pkg::out_item_t                 out_item_o
);
  import cprs_pkg::*;

  localparam int unsigned PCW = $clog2(MAX_PAGES + 1);
  localparam int unsigned STW = (PCW > START_W) ? PCW : START_W;

  // Buffer state.
  logic [FRAME_BITS-1:0] expected_q, expected_d;
  logic [STW-1:0]        run_start_q, run_start_d;
  logic [RUN_W-1:0]      run_len_q, run_len_d;
  logic [PCW-1:0]        page_count_q, page_count_d;
  logic                  have_run_q, have_run_d;
  logic                  ovf_q, ovf_d;
  logic [LOG2_W-1:0]     chunk_log2_q, chunk_log2_d;

  // Segments of the current item and its flags.
  logic [STW-1:0]   a_start_q, a_start_d;
  logic [RUN_W-1:0] a_len_q, a_len_d;
  logic [STW-1:0]   b_start_q, b_start_d;
  logic [RUN_W-1:0] b_len_q, b_len_d;
  logic             last_q;
  logic             item_ovf_q;

  // Output register.
  logic      out_valid_q;
  out_item_t out_q;

  logic [FRAME_BITS-1:0] frame;
  logic                  in_range;
  logic                  cont;
  logic [LOG2_W-1:0]     chunk_lg;
  logic [RUN_W-1:0]      chunk_len;
  logic [RUN_W-1:0]      len1;
  logic [STW-1:0]        st1;
  logic [RUN_W-1:0]      a_pow;
  logic [RUN_W-1:0]      b_pow;

  // Work out the segments and the next buffer state for an arriving page.
  always_comb begin
    frame     = FRAME_BITS'(in_item_i.frame_number);
    in_range  = page_count_q < PCW'(MAX_PAGES);
    cont      = have_run_q && (frame == expected_q);
    chunk_lg  = (page_count_q == '0) ? clamp_log2(max_set_log2_i) : chunk_log2_q;
    chunk_len = RUN_W'(1) << chunk_lg;

    a_start_d    = run_start_q;
    a_len_d      = '0;
    b_start_d    = run_start_q;
    b_len_d      = '0;
    expected_d   = expected_q;
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    page_count_d = page_count_q;
    have_run_d   = have_run_q;
    ovf_d        = ovf_q;
    chunk_log2_d = chunk_log2_q;
    len1         = run_len_q + RUN_W'(1);
    st1          = run_start_q;

    if (in_range) begin
      if (!cont) begin
        // A break flushes the open run and starts a new one here.
        a_len_d = run_len_q;
        len1    = RUN_W'(1);
        st1     = STW'(page_count_q);
      end
      if (len1 >= chunk_len) begin
        b_start_d   = st1;
        b_len_d     = chunk_len;
        run_start_d = st1 + STW'(chunk_len);
        run_len_d   = '0;
      end else begin
        run_start_d = st1;
        run_len_d   = len1;
        if (in_item_i.last_page) begin
          b_start_d = st1;
          b_len_d   = len1;
        end
      end
      expected_d   = frame + FRAME_BITS'(1);
      page_count_d = page_count_q + PCW'(1);
      have_run_d   = 1'b1;
      chunk_log2_d = chunk_lg;
    end else begin
      // Pages beyond capacity are dropped; the last mark still flushes.
      ovf_d = 1'b1;
      if (in_item_i.last_page) begin
        b_len_d = run_len_q;
      end
    end
  end

  assign a_pow = top_pow2(a_len_q);
  assign b_pow = top_pow2(b_len_q);

  // Buffer state registers, cleared at the end of each buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q   <= '0;
      run_start_q  <= '0;
      run_len_q    <= '0;
      page_count_q <= '0;
      have_run_q   <= 1'b0;
      ovf_q        <= 1'b0;
      chunk_log2_q <= '0;
    end else if (cmd_i.load) begin
      if (in_item_i.last_page) begin
        expected_q   <= '0;
        run_start_q  <= '0;
        run_len_q    <= '0;
        page_count_q <= '0;
        have_run_q   <= 1'b0;
        ovf_q        <= 1'b0;
        chunk_log2_q <= '0;
      end else begin
        expected_q   <= expected_d;
        run_start_q  <= run_start_d;
        run_len_q    <= run_len_d;
        page_count_q <= page_count_d;
        have_run_q   <= have_run_d;
        ovf_q        <= ovf_d;
        chunk_log2_q <= chunk_log2_d;
      end
    end
  end

  // Segment registers: loaded with the item, consumed one set at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_len_q <= '0;
      b_len_q <= '0;
    end else if (cmd_i.load) begin
      a_len_q <= a_len_d;
      b_len_q <= b_len_d;
    end else if (cmd_i.emit_a) begin
      a_len_q <= a_len_q ^ a_pow;
    end else if (cmd_i.emit_b) begin
      b_len_q <= b_len_q ^ b_pow;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_start_q  <= a_start_d;
      b_start_q  <= b_start_d;
      last_q     <= in_item_i.last_page;
      item_ovf_q <= ovf_d;
    end else if (cmd_i.emit_a) begin
      a_start_q <= a_start_q + STW'(a_pow);
    end else if (cmd_i.emit_b) begin
      b_start_q <= b_start_q + STW'(b_pow);
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_a || cmd_i.emit_b) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_a) begin
      out_q.set_start <= START_W'(a_start_q);
      out_q.set_pages <= a_pow;
      out_q.last_set  <= last_q && (a_len_q == a_pow) && (b_len_q == '0);
      out_q.overflow  <= item_ovf_q;
    end else if (cmd_i.emit_b) begin
      out_q.set_start <= START_W'(b_start_q);
      out_q.set_pages <= b_pow;
      out_q.last_set  <= last_q && (b_len_q == b_pow);
      out_q.overflow  <= item_ovf_q;
    end
  end

  // Status for the controller.
  always_comb begin
    status_o.a_go     = a_len_d != '0;
    status_o.b_go     = b_len_d != '0;
    status_o.a_done   = a_len_q == a_pow;
    status_o.b_done   = b_len_q == b_pow;
    status_o.b_left   = b_len_q != '0;
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/contiguous_page_run_splitter.sv =====
// A page is accepted only while no page sets of the previous page are still waiting to be emitted.
// Most pages continue a run and cause no set, so they are taken every cycle.
// The first set of a page goes from the segment registers into the output register once that register is free.
// The set rate is set by the output register, which is loaded with one set per cycle while it is empty or read.
// Reset clears the run state and the controller and sets max_set_log2 to nine.
// Top level of the contiguous page run splitter with its configuration register.
module contiguous_page_run_splitter #(
  parameter int unsigned MAX_PAGES  = cprs_pkg::MAX_PAGES_DEF,
  parameter int unsigned FRAME_BITS = cprs_pkg::FRAME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cprs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cprs_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cprs_pkg::*;

  logic [LOG2_W-1:0] max_set_log2_q;
  dp_cmd_t           cmd;
  dp_status_t        status;

  // Configuration register, written in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_set_log2_q <= MAX_SET_LOG2_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_SET_LOG2)) begin
      max_set_log2_q <= pwdata[LOG2_W-1:0];
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_SET_LOG2) begin
      prdata = 32'(max_set_log2_q);
    end
  end

  assign pready = 1'b1;

  cprs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cprs_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_item_i      (in_item_i),
    .max_set_log2_i (max_set_log2_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_o     (out_item_o)
  );

endmodule
